// ===== rtl/pvpg_pkg.sv =====
// Shared types, codes and constant tables of the varicode phase generator.
package pvpg_pkg;

    // Input kind codes.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_IDLE  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    localparam int CODE_W = 12;
    localparam int LEN_W  = 4;

    // Phase step of two quarter turns for a phase reversal.
    localparam logic [1:0] PHASE_FLIP = 2'd2;

    typedef enum logic [1:0] {
        OP_CHAR  = 2'd0,
        OP_IDLE  = 2'd1,
        OP_START = 2'd2
    } op_t;

    // Classified command word passed from the front part to the back part.
    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // Status of the command queue as the back part sees it.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    localparam logic [CODE_W-1:0] VC_CODE [128] = '{
        12'd2732, 12'd2924, 12'd2996, 12'd3548, 12'd2988, 12'd3452, 12'd3004, 12'd3060,
        12'd3068, 12'd956,  12'd116,  12'd3516, 12'd2932, 12'd124,  12'd3540, 12'd3756,
        12'd3036, 12'd3028, 12'd3764, 12'd3772, 12'd3436, 12'd3500, 12'd3508, 12'd3420,
        12'd3564, 12'd3572, 12'd3804, 12'd3412, 12'd3444, 12'd3820, 12'd3052, 12'd3580,
        12'd4,    12'd2044, 12'd1404, 12'd2004, 12'd1900, 12'd2900, 12'd2796, 12'd1532,
        12'd1004, 12'd988,  12'd1468, 12'd1916, 12'd468,  12'd212,  12'd348,  12'd1724,
        12'd732,  12'd756,  12'd948,  12'd1020, 12'd1500, 12'd1388, 12'd1452, 12'd1716,
        12'd1708, 12'd1756, 12'd980,  12'd1780, 12'd1972, 12'd340,  12'd1884, 12'd2748,
        12'd2804, 12'd500,  12'd940,  12'd692,  12'd724,  12'd476,  12'd876,  12'd1012,
        12'd1364, 12'd508,  12'd2036, 12'd1524, 12'd860,  12'd748,  12'd884,  12'd684,
        12'd852,  12'd1908, 12'd700,  12'd444,  12'd436,  12'd1372, 12'd1748, 12'd1396,
        12'd1492, 12'd1516, 12'd2740, 12'd2012, 12'd1980, 12'd2028, 12'd2812, 12'd1460,
        12'd2940, 12'd44,   12'd380,  12'd188,  12'd180,  12'd12,   12'd244,  12'd364,
        12'd172,  12'd52,   12'd1964, 12'd764,  12'd108,  12'd236,  12'd60,   12'd28,
        12'd252,  12'd1788, 12'd84,   12'd92,   12'd20,   12'd220,  12'd492,  12'd428,
        12'd892,  12'd372,  12'd1876, 12'd2780, 12'd1772, 12'd2772, 12'd2908, 12'd3796
    };

    localparam logic [LEN_W-1:0] VC_LEN [128] = '{
        4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
        4'd11, 4'd9,  4'd6,  4'd11, 4'd11, 4'd6,  4'd11, 4'd11,
        4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
        4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
        4'd2,  4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd10,
        4'd9,  4'd9,  4'd10, 4'd10, 4'd8,  4'd7,  4'd8,  4'd10,
        4'd9,  4'd9,  4'd9,  4'd9,  4'd10, 4'd10, 4'd10, 4'd10,
        4'd10, 4'd10, 4'd9,  4'd10, 4'd10, 4'd8,  4'd10, 4'd11,
        4'd11, 4'd8,  4'd9,  4'd9,  4'd9,  4'd8,  4'd9,  4'd9,
        4'd10, 4'd8,  4'd10, 4'd10, 4'd9,  4'd9,  4'd9,  4'd9,
        4'd9,  4'd10, 4'd9,  4'd8,  4'd8,  4'd10, 4'd10, 4'd10,
        4'd10, 4'd10, 4'd11, 4'd10, 4'd10, 4'd10, 4'd11, 4'd10,
        4'd11, 4'd5,  4'd8,  4'd7,  4'd7,  4'd3,  4'd7,  4'd8,
        4'd7,  4'd5,  4'd10, 4'd9,  4'd6,  4'd7,  4'd5,  4'd4,
        4'd7,  4'd10, 4'd6,  4'd6,  4'd4,  4'd7,  4'd8,  4'd8,
        4'd9,  4'd8,  4'd10, 4'd11, 4'd10, 4'd11, 4'd11, 4'd11
    };

    // QPSK phase step in quarter turns for each shift register value.
    localparam logic [1:0] CONV_STEP [32] = '{
        2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd0, 2'd2, 2'd1,
        2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3,
        2'd1, 2'd2, 2'd0, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2,
        2'd3, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0
    };

endpackage

// ===== rtl/pvpg_front.sv =====
// Front part: accepts input words, classifies them and looks up the varicode.
module pvpg_front (
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              kind,
    input  logic [6:0]              character,
    input  pvpg_pkg::queue_status_t q_status,
    output logic                    q_wr,
    output pvpg_pkg::cmd_t          q_wr_data
);

    logic accept;
    logic keep;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    always_comb
    begin
        keep           = 1'b1;
        q_wr_data.code = pvpg_pkg::VC_CODE[character];
        q_wr_data.len  = pvpg_pkg::VC_LEN[character];
        q_wr_data.op   = pvpg_pkg::OP_CHAR;
        unique case (kind)
            pvpg_pkg::KIND_CHAR:  q_wr_data.op = pvpg_pkg::OP_CHAR;
            pvpg_pkg::KIND_IDLE:  q_wr_data.op = pvpg_pkg::OP_IDLE;
            pvpg_pkg::KIND_START: q_wr_data.op = pvpg_pkg::OP_START;
            // The unused kind is taken and dropped without effect.
            default:              keep = 1'b0;
        endcase
    end

    assign q_wr = accept && keep;

endmodule

// ===== rtl/pvpg_queue.sv =====
// Short command queue between the front and back parts.
module pvpg_queue #(
    parameter int DEPTH = pvpg_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr,
    input  pvpg_pkg::cmd_t          wr_data,
    input  logic                    rd,
    output pvpg_pkg::cmd_t          rd_data,
    output pvpg_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pvpg_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == FULL_CNT);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/pvpg_back.sv =====
// Back part: steps through the varicode bits and keeps carrier phase and shift state.
module pvpg_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_qpsk_mode,
    input  pvpg_pkg::queue_status_t q_status,
    input  pvpg_pkg::cmd_t          q_rd_data,
    output logic                    q_rd,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              phase_quarter,
    output logic                    sent_bit,
    output logic                    last_of_item
);

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_SEND  = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    pvpg_pkg::cmd_t              cmd_reg, cmd_next;
    logic [pvpg_pkg::LEN_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [4:0]                  shift_reg, shift_next;
    logic                        qpsk_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_phase_reg, out_phase_next;
    logic                        out_bit_reg, out_bit_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_free;
    logic                        load;
    logic                        cur_bit;
    logic [4:0]                  shift_step;

    assign out_free      = !out_valid_reg || pop;
    assign empty         = !out_valid_reg;
    assign phase_quarter = out_phase_reg;
    assign sent_bit      = out_bit_reg;
    assign last_of_item  = out_last_reg;

    assign cur_bit    = cmd_reg.code[bit_idx_reg];
    assign shift_step = {shift_reg[3:0], cur_bit};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        bit_idx_next   = bit_idx_reg;
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !pop;
        out_phase_next = out_phase_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;
        q_rd           = 1'b0;
        load           = 1'b0;
        unique case (state_reg)
            ST_FETCH:
            begin
                if (!q_status.empty)
                begin
                    q_rd         = 1'b1;
                    cmd_next     = q_rd_data;
                    bit_idx_next = q_rd_data.len;
                    if (q_rd_data.op == pvpg_pkg::OP_START)
                    begin
                        shift_next = '0;
                    end
                    else
                    begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (cmd_reg.op == pvpg_pkg::OP_IDLE)
                    begin
                        phase_next    = phase_reg + pvpg_pkg::PHASE_FLIP;
                        out_bit_next  = 1'b0;
                        out_last_next = 1'b1;
                    end
                    else
                    begin
                        if (qpsk_reg)
                        begin
                            shift_next = shift_step;
                            phase_next = phase_reg + pvpg_pkg::CONV_STEP[shift_step];
                        end
                        else if (!cur_bit)
                        begin
                            phase_next = phase_reg + pvpg_pkg::PHASE_FLIP;
                        end
                        out_bit_next  = cur_bit;
                        out_last_next = (bit_idx_reg == '0);
                        bit_idx_next  = bit_idx_reg - 1'b1;
                    end
                    out_valid_next = 1'b1;
                    out_phase_next = phase_next;
                    if (out_last_next)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            phase_reg     <= '0;
            shift_reg     <= '0;
            qpsk_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                qpsk_reg <= cfg_qpsk_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        bit_idx_reg   <= bit_idx_next;
        out_phase_reg <= out_phase_next;
        out_bit_reg   <= out_bit_next;
        out_last_reg  <= out_last_next;
    end

    // The phase moves only together with a new result word.
    a_phase_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(phase_reg))
        else $error("phase changed without a result word");

    // An idle period gives exactly one word, marked last.
    a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cmd_reg.op == pvpg_pkg::OP_IDLE) |=> (out_valid_reg && out_last_reg))
        else $error("idle period did not give a single last word");

    // The last word of an item sends the sequencer back to fetch.
    a_last_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_last_next) |=> (state_reg == ST_FETCH))
        else $error("sequencer kept sending after the last word");

    // A start command clears the shift register and leaves the phase alone.
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_rd && q_rd_data.op == pvpg_pkg::OP_START)
        |=> (shift_reg == '0 && $stable(phase_reg)))
        else $error("start command did not clear the shift register");

    // The result register is never overwritten while its word waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result word overwritten");

endmodule

// ===== rtl/psk31_varicode_phase_generator_core.sv =====
// Top level of the PSK31 varicode phase generator: front, command queue and back.
//
//  Channel   | Handshake                    | Word
//  ----------+------------------------------+----------------------------------------
//  input     | push / full                  | kind, character
//  result    | pop / empty                  | phase_quarter, sent_bit, last_of_item
//  config    | cfg_valid / cfg_ready        | qpsk_mode
//
// A character gives len+1 result words, one per cycle while pop keeps up, after the back
// sequencer fetches it from the command queue in its fetch state; an idle item gives one
// result word and a start item none. The sequencer's bit loop sets the number of words.
// The front takes words whenever the command queue has room, so it runs ahead of the
// back by up to QUEUE_DEPTH commands. A single result register holds back the sequencer
// while its word is not popped. Reset clears the phase, the shift register and the mode.
module psk31_varicode_phase_generator_core #(
    parameter int QUEUE_DEPTH = pvpg_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] kind,
    input  logic [6:0] character,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] phase_quarter,
    output logic       sent_bit,
    output logic       last_of_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       qpsk_mode
);

    pvpg_pkg::queue_status_t q_status;
    pvpg_pkg::cmd_t          q_wr_data;
    pvpg_pkg::cmd_t          q_rd_data;
    logic                    q_wr;
    logic                    q_rd;

    // The mode register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    pvpg_front u_front (
        .push      (push),
        .full      (full),
        .kind      (kind),
        .character (character),
        .q_status  (q_status),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data)
    );

    pvpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    pvpg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_qpsk_mode (qpsk_mode),
        .q_status      (q_status),
        .q_rd_data     (q_rd_data),
        .q_rd          (q_rd),
        .empty         (empty),
        .pop           (pop),
        .phase_quarter (phase_quarter),
        .sent_bit      (sent_bit),
        .last_of_item  (last_of_item)
    );

endmodule
